// ===== rtl/mepg_pkg.sv =====
// Shared types and codes for the midpoint ellipse point generator.
`timescale 1ns / 1ps
`default_nettype none
package mepg_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ_RX,
		ST_SQ_RY,
		ST_A_RY,
		ST_INIT,
		ST_RC_TX,
		ST_RC_TY,
		ST_RC_BT,
		ST_RC_AT,
		ST_RC_AB,
		ST_RC_FIN,
		ST_EMIT
	} state_t;

	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_RX_RX,
		MUL_RY_RY,
		MUL_A_RY,
		MUL_TX_TX,
		MUL_TY_TY,
		MUL_B_T1,
		MUL_A_T2,
		MUL_A_B
	} mul_sel_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_STORE_A,
		OP_STORE_B,
		OP_INIT,
		OP_STORE_T1,
		OP_STORE_T2,
		OP_ACC_LOAD,
		OP_ACC_ADD,
		OP_RC_FIN,
		OP_EMIT
	} dp_op_t;

	typedef enum logic [1:0] {
		RGN_IDLE   = 2'd0,
		RGN_FIRST  = 2'd1,
		RGN_SECOND = 2'd2,
		RGN_DONE   = 2'd3
	} region_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		dp_op_t   op;
	} cmd_t;

	typedef struct packed {
		logic region_change;
		logic out_free;
	} status_t;

	localparam int unsigned CFG_UPPER_HALF = 0;
	localparam int unsigned CFG_SKIP       = 1;

endpackage
`default_nettype wire

// ===== rtl/mepg_if.sv =====
// Item and result stream interfaces of the ellipse point generator.
`timescale 1ns / 1ps
`default_nettype none
interface mepg_item_if #(
	parameter int RADIUS_BITS = 10,
	parameter int COORD_BITS  = 12
);
	logic                         valid;
	logic                         ready;
	logic                         command;
	logic        [RADIUS_BITS-1:0] radius_x;
	logic        [RADIUS_BITS-1:0] radius_y;
	logic signed [COORD_BITS-1:0]  centre_x;
	logic signed [COORD_BITS-1:0]  centre_y;

	modport source (output valid, command, radius_x, radius_y, centre_x, centre_y,
		input ready);
	modport sink (input valid, command, radius_x, radius_y, centre_x, centre_y,
		output ready);
endinterface

interface mepg_result_if #(
	parameter int COORD_BITS = 12
);
	logic                       valid;
	logic                       ready;
	logic signed [COORD_BITS:0] right_x;
	logic signed [COORD_BITS:0] left_x;
	logic signed [COORD_BITS:0] upper_y;
	logic signed [COORD_BITS:0] lower_y;
	logic                       lower_valid;
	logic                       visible;
	logic                       done_res;

	modport source (output valid, right_x, left_x, upper_y, lower_y, lower_valid,
		visible, done_res, input ready);
	modport sink (input valid, right_x, left_x, upper_y, lower_y, lower_valid,
		visible, done_res, output ready);
endinterface
`default_nettype wire

// ===== rtl/mepg_ctrl.sv =====
// Sequencer for start setup, region change and point emission.
`timescale 1ns / 1ps
`default_nettype none
module mepg_ctrl
	import mepg_pkg::*;
(
	input  wire     clk,
	input  wire     arst_n,
	input  wire     in_valid,
	input  wire     in_command,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd.mul_sel = MUL_NONE;
		cmd.op      = OP_NONE;
		in_ready    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!in_command) begin
						cmd.op  = OP_LATCH;
						state_d = ST_SQ_RX;
					end else if (status.region_change) begin
						state_d = ST_RC_TX;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_SQ_RX: begin
				cmd.mul_sel = MUL_RX_RX;
				state_d     = ST_SQ_RY;
			end
			ST_SQ_RY: begin
				cmd.op      = OP_STORE_A;
				cmd.mul_sel = MUL_RY_RY;
				state_d     = ST_A_RY;
			end
			ST_A_RY: begin
				cmd.op      = OP_STORE_B;
				cmd.mul_sel = MUL_A_RY;
				state_d     = ST_INIT;
			end
			ST_INIT: begin
				cmd.op  = OP_INIT;
				state_d = ST_IDLE;
			end
			ST_RC_TX: begin
				cmd.mul_sel = MUL_TX_TX;
				state_d     = ST_RC_TY;
			end
			ST_RC_TY: begin
				cmd.op      = OP_STORE_T1;
				cmd.mul_sel = MUL_TY_TY;
				state_d     = ST_RC_BT;
			end
			ST_RC_BT: begin
				cmd.op      = OP_STORE_T2;
				cmd.mul_sel = MUL_B_T1;
				state_d     = ST_RC_AT;
			end
			ST_RC_AT: begin
				cmd.op      = OP_ACC_LOAD;
				cmd.mul_sel = MUL_A_T2;
				state_d     = ST_RC_AB;
			end
			ST_RC_AB: begin
				cmd.op      = OP_ACC_ADD;
				cmd.mul_sel = MUL_A_B;
				state_d     = ST_RC_FIN;
			end
			ST_RC_FIN: begin
				cmd.op  = OP_RC_FIN;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.op  = OP_EMIT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/mepg_datapath.sv =====
// Ellipse state registers, shared multiplier, step update and result register.
`timescale 1ns / 1ps
`default_nettype none
module mepg_datapath
	import mepg_pkg::*;
#(
	parameter int RADIUS_BITS = 10,
	parameter int COORD_BITS  = 12
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  cmd_t                         cmd,
	output status_t                      status,
	input  wire                          upper_half_only,
	input  wire  [7:0]                   skip_leading,
	input  wire  [RADIUS_BITS-1:0]       radius_x,
	input  wire  [RADIUS_BITS-1:0]       radius_y,
	input  wire  signed [COORD_BITS-1:0] centre_x,
	input  wire  signed [COORD_BITS-1:0] centre_y,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic signed [COORD_BITS:0]   right_x,
	output logic signed [COORD_BITS:0]   left_x,
	output logic signed [COORD_BITS:0]   upper_y,
	output logic signed [COORD_BITS:0]   lower_y,
	output logic                         lower_valid,
	output logic                         visible,
	output logic                         done_res
);

	localparam int R  = RADIUS_BITS;
	localparam int AW = 2 * R;
	localparam int BW = 2 * R + 4;
	localparam int PW = AW + BW;
	localparam int SW = 3 * R + 6;
	localparam int DW = 4 * R + 8;
	localparam int XW = R + 1;
	localparam int YW = R + 2;
	localparam int EW = ((COORD_BITS > YW) ? COORD_BITS : YW) + 1;

	region_t                 region_q;
	logic        [XW-1:0]    x_q;
	logic signed [YW-1:0]    y_q;
	logic signed [SW-1:0]    sx_q, sy_q;
	logic signed [DW-1:0]    dec_q, acc_q;
	logic        [7:0]       count_q;
	logic        [R-1:0]     rx_q, ry_q;
	logic signed [COORD_BITS-1:0] cx_q, cy_q;
	logic        [AW-1:0]    a_q, b_q;
	logic        [BW-1:0]    t1_q, t2_q;
	logic        [PW-1:0]    p_q;
	logic                    out_valid_q;

	logic        [AW-1:0]    mul_a;
	logic        [BW-1:0]    mul_b;
	logic        [PW-1:0]    prod;
	logic        [YW-1:0]    tx;
	logic signed [YW-1:0]    ty;
	logic        [YW-1:0]    ty_abs;

	logic signed [SW-1:0]    sx_inc, sy_dec;
	logic signed [DW-1:0]    a_ext, b_ext, p_ext, sx_inc_ext, sy_dec_ext;
	logic                    dec_neg, live, vis;
	logic signed [EW-1:0]    cx_e, cy_e, x_e, y_e, rx_sum, lx_sum, uy_sum, ly_sum;

	assign tx     = {x_q, 1'b1};
	assign ty     = y_q - YW'(1);
	assign ty_abs = ty[YW-1] ? YW'(-ty) : YW'(ty);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.mul_sel)
			MUL_RX_RX: begin
				mul_a = AW'(rx_q);
				mul_b = BW'(rx_q);
			end
			MUL_RY_RY: begin
				mul_a = AW'(ry_q);
				mul_b = BW'(ry_q);
			end
			MUL_A_RY: begin
				mul_a = a_q;
				mul_b = BW'(ry_q);
			end
			MUL_TX_TX: begin
				mul_a = AW'(tx);
				mul_b = BW'(tx);
			end
			MUL_TY_TY: begin
				mul_a = AW'(ty_abs);
				mul_b = BW'(ty_abs);
			end
			MUL_B_T1: begin
				mul_a = b_q;
				mul_b = t1_q;
			end
			MUL_A_T2: begin
				mul_a = a_q;
				mul_b = t2_q;
			end
			MUL_A_B: begin
				mul_a = a_q;
				mul_b = BW'(b_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = PW'(mul_a) * PW'(mul_b);

	assign a_ext      = DW'(signed'({1'b0, a_q}));
	assign b_ext      = DW'(signed'({1'b0, b_q}));
	assign p_ext      = DW'(signed'({1'b0, p_q}));
	assign sx_inc     = sx_q + SW'(signed'({1'b0, b_q, 1'b0}));
	assign sy_dec     = sy_q - SW'(signed'({1'b0, a_q, 1'b0}));
	assign sx_inc_ext = DW'(sx_inc);
	assign sy_dec_ext = DW'(sy_dec);
	assign dec_neg    = dec_q[DW-1];

	assign live = (region_q == RGN_FIRST) || ((region_q == RGN_SECOND) && !y_q[YW-1]);
	assign vis  = count_q >= skip_leading;

	assign cx_e   = EW'(cx_q);
	assign cy_e   = EW'(cy_q);
	assign x_e    = EW'(signed'({1'b0, x_q}));
	assign y_e    = EW'(y_q);
	assign rx_sum = cx_e + x_e;
	assign lx_sum = cx_e - x_e;
	assign uy_sum = cy_e + y_e;
	assign ly_sum = cy_e - y_e;

	assign status.region_change = (region_q == RGN_FIRST) && !(sx_q < sy_q);
	assign status.out_free      = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		p_q <= prod;
		unique case (cmd.op)
			OP_LATCH: begin
				rx_q <= radius_x;
				ry_q <= radius_y;
				cx_q <= centre_x;
				cy_q <= centre_y;
			end
			OP_STORE_A: a_q <= AW'(p_q);
			OP_STORE_B: b_q <= AW'(p_q);
			OP_INIT: begin
				x_q   <= '0;
				y_q   <= YW'(signed'({1'b0, ry_q}));
				sx_q  <= '0;
				sy_q  <= signed'(SW'({p_q, 1'b0}));
				dec_q <= (b_ext <<< 2) - (p_ext <<< 2) + a_ext;
			end
			OP_STORE_T1: t1_q <= BW'(p_q);
			OP_STORE_T2: t2_q <= BW'(p_q);
			OP_ACC_LOAD: acc_q <= p_ext;
			OP_ACC_ADD:  acc_q <= acc_q + (p_ext <<< 2);
			OP_RC_FIN:   dec_q <= acc_q - (p_ext <<< 2);
			OP_EMIT: begin
				if (live) begin
					right_x <= rx_sum[COORD_BITS:0];
					left_x  <= lx_sum[COORD_BITS:0];
					upper_y <= uy_sum[COORD_BITS:0];
					lower_y <= ly_sum[COORD_BITS:0];
					lower_valid <= vis && !upper_half_only;
					visible  <= vis;
					done_res <= 1'b0;
					if (region_q == RGN_FIRST) begin
						x_q  <= x_q + XW'(1);
						sx_q <= sx_inc;
						if (dec_neg) begin
							dec_q <= dec_q + ((sx_inc_ext + b_ext) <<< 2);
						end else begin
							y_q   <= y_q - YW'(1);
							sy_q  <= sy_dec;
							dec_q <= dec_q + ((sx_inc_ext - sy_dec_ext + b_ext) <<< 2);
						end
					end else begin
						y_q  <= y_q - YW'(1);
						sy_q <= sy_dec;
						if (!dec_neg && (dec_q != '0)) begin
							dec_q <= dec_q + ((a_ext - sy_dec_ext) <<< 2);
						end else begin
							x_q   <= x_q + XW'(1);
							sx_q  <= sx_inc;
							dec_q <= dec_q + ((sx_inc_ext - sy_dec_ext + b_ext) <<< 2);
						end
					end
				end else begin
					right_x     <= '0;
					left_x      <= '0;
					upper_y     <= '0;
					lower_y     <= '0;
					lower_valid <= 1'b0;
					visible     <= 1'b0;
					done_res    <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q    <= RGN_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			priority if (cmd.op == OP_INIT) begin
				region_q <= RGN_FIRST;
				count_q  <= '0;
			end else if (cmd.op == OP_RC_FIN) begin
				region_q <= RGN_SECOND;
				count_q  <= '0;
			end else if (cmd.op == OP_EMIT) begin
				if (live) begin
					if (count_q != 8'hFF) begin
						count_q <= count_q + 8'd1;
					end
				end else if (region_q == RGN_SECOND) begin
					region_q <= RGN_DONE;
				end
			end else begin
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== rtl/midpoint_ellipse_point_generator_unit.sv =====
// Top level of the midpoint ellipse point generator with its APB register port.
`timescale 1ns / 1ps
`default_nettype none
// A start transaction (command 0) latches the radii and centre and uses the
// shared multiplier to form rx^2, ry^2 and rx^2*ry; it yields no result. A
// step transaction (command 1) is accepted and then moves to the emit state,
// which loads the result register and advances the decision value. The step
// that crosses into the second region first passes through the region-change
// states, as the new decision value needs five dependent products
// on the same multiplier. The result register lets the next transaction be
// accepted while a result still waits; a step then holds in its emit cycle
// until that result is taken. Registers: 0x0 upper_half_only,
// 0x4 skip_leading; write them only while the block is idle.
module midpoint_ellipse_point_generator_unit
	import mepg_pkg::*;
#(
	parameter int RADIUS_BITS = 10,
	parameter int COORD_BITS  = 12
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          psel,
	input  wire          penable,
	input  wire          pwrite,
	input  wire  [2:0]   paddr,
	input  wire  [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	mepg_item_if.sink    item,
	mepg_result_if.source result
);

	logic       upper_q;
	logic [7:0] skip_q;
	logic       cfg_write;
	cmd_t       cmd;
	status_t    status;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= 1'b0;
			skip_q  <= '0;
		end else if (cfg_write) begin
			if (32'(paddr[2]) == CFG_UPPER_HALF) begin
				upper_q <= pwdata[0];
			end else begin
				skip_q <= pwdata[7:0];
			end
		end
	end

	assign prdata = (32'(paddr[2]) == CFG_SKIP) ? {24'b0, skip_q} : {31'b0, upper_q};

	mepg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (item.valid),
		.in_command (item.command),
		.in_ready   (item.ready),
		.status     (status),
		.cmd        (cmd)
	);

	mepg_datapath #(
		.RADIUS_BITS (RADIUS_BITS),
		.COORD_BITS  (COORD_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.upper_half_only (upper_q),
		.skip_leading    (skip_q),
		.radius_x        (item.radius_x),
		.radius_y        (item.radius_y),
		.centre_x        (item.centre_x),
		.centre_y        (item.centre_y),
		.out_valid       (result.valid),
		.out_ready       (result.ready),
		.right_x         (result.right_x),
		.left_x          (result.left_x),
		.upper_y         (result.upper_y),
		.lower_y         (result.lower_y),
		.lower_valid     (result.lower_valid),
		.visible         (result.visible),
		.done_res        (result.done_res)
	);

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> !item.ready)
		else $error("item accepted in consecutive cycles");

	a_visible_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.visible) |-> !result.done_res)
		else $error("visible result flagged done");

	a_lower_needs_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.lower_valid) |-> result.visible)
		else $error("lower points valid on a hidden result");
`endif

endmodule
`default_nettype wire

// ===== tb/mepg_tb_pkg.sv =====
// Command codes shared by the ellipse generator testbench files.
`timescale 1ns / 1ps
package mepg_tb_pkg;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

endpackage

// ===== tb/mepg_checker.sv =====
// Checker: traces the ellipse from accepted transactions and compares every result.
`timescale 1ns / 1ps
module mepg_checker
	import mepg_pkg::*;
	import mepg_tb_pkg::*;
#(
	parameter int RADIUS_BITS = 10,
	parameter int COORD_BITS  = 12
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	input  wire         pready,
	mepg_item_if        item,
	mepg_result_if      result,
	output int          fail_count,
	output int          pending
);

	localparam int OUT_W = COORD_BITS + 1;

	typedef struct {
		logic signed [COORD_BITS:0] right_x;
		logic signed [COORD_BITS:0] left_x;
		logic signed [COORD_BITS:0] upper_y;
		logic signed [COORD_BITS:0] lower_y;
		logic                       lower_valid;
		logic                       visible;
		logic                       done_res;
	} point_set_t;

	point_set_t expected_points[$];
	int         mismatches;

	logic       upper_only;
	logic [7:0] skip_count;

	region_t region;
	longint  off_x, off_y, slope_x, slope_y, decision;
	int      iter;
	longint  rad_x, rad_y, ctr_x, ctr_y;

	function automatic bit trace_item(input logic cmd,
		input logic [RADIUS_BITS-1:0] rx_in, input logic [RADIUS_BITS-1:0] ry_in,
		input logic signed [COORD_BITS-1:0] cx_in, input logic signed [COORD_BITS-1:0] cy_in,
		output point_set_t ps);
		longint a, b, tx, ty;
		bit     shown, pos;
		ps = '{default: 0};
		if (cmd == CMD_START) begin
			rad_x    = rx_in;
			rad_y    = ry_in;
			ctr_x    = cx_in;
			ctr_y    = cy_in;
			a        = rad_x * rad_x;
			b        = rad_y * rad_y;
			off_x    = 0;
			off_y    = rad_y;
			slope_x  = 0;
			slope_y  = 2 * a * rad_y;
			decision = 4 * b - 4 * a * rad_y + a;
			iter     = 0;
			region   = RGN_FIRST;
			return 1'b0;
		end
		a = rad_x * rad_x;
		b = rad_y * rad_y;
		if (region == RGN_FIRST && !(slope_x < slope_y)) begin
			tx       = 2 * off_x + 1;
			ty       = off_y - 1;
			decision = b * tx * tx + 4 * a * ty * ty - 4 * a * b;
			iter     = 0;
			region   = RGN_SECOND;
		end
		if (region == RGN_SECOND && off_y < 0)
			region = RGN_DONE;
		if (region != RGN_FIRST && region != RGN_SECOND) begin
			ps.done_res = 1'b1;
			return 1'b1;
		end
		shown          = iter >= int'(skip_count);
		ps.right_x     = OUT_W'(ctr_x + off_x);
		ps.left_x      = OUT_W'(ctr_x - off_x);
		ps.upper_y     = OUT_W'(ctr_y + off_y);
		ps.lower_y     = OUT_W'(ctr_y - off_y);
		ps.lower_valid = shown && !upper_only;
		ps.visible     = shown;
		if (region == RGN_FIRST) begin
			off_x++;
			slope_x += 2 * b;
			if (decision < 0) begin
				decision += 4 * (slope_x + b);
			end else begin
				off_y--;
				slope_y -= 2 * a;
				decision += 4 * (slope_x - slope_y + b);
			end
		end else begin
			pos = decision > 0;
			off_y--;
			slope_y -= 2 * a;
			if (pos) begin
				decision += 4 * (a - slope_y);
			end else begin
				off_x++;
				slope_x += 2 * b;
				decision += 4 * (slope_x - slope_y + b);
			end
		end
		if (iter < 255)
			iter++;
		return 1'b1;
	endfunction

	function automatic void check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		point_set_t want, got;
		if (!arst_n) begin
			expected_points.delete();
			mismatches = 0;
			upper_only = 1'b0;
			skip_count = '0;
			region     = RGN_IDLE;
			off_x      = 0;
			off_y      = 0;
			slope_x    = 0;
			slope_y    = 0;
			decision   = 0;
			iter       = 0;
			rad_x      = 0;
			rad_y      = 0;
			ctr_x      = 0;
			ctr_y      = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_points.size() == 0) begin
					$error("result transaction with no expected point set");
					mismatches++;
				end else begin
					want = expected_points.pop_front();
					check_field("right_x", want.right_x, result.right_x);
					check_field("left_x", want.left_x, result.left_x);
					check_field("upper_y", want.upper_y, result.upper_y);
					check_field("lower_y", want.lower_y, result.lower_y);
					check_field("lower_valid", want.lower_valid, result.lower_valid);
					check_field("visible", want.visible, result.visible);
					check_field("done_res", want.done_res, result.done_res);
				end
			end
			if (item.valid && item.ready) begin
				if (trace_item(item.command, item.radius_x, item.radius_y,
						item.centre_x, item.centre_y, got))
					expected_points.push_back(got);
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr == 3'(4 * CFG_UPPER_HALF))
					upper_only = pwdata[0];
				else if (paddr == 3'(4 * CFG_SKIP))
					skip_count = pwdata[7:0];
			end
			fail_count <= mismatches;
			pending    <= expected_points.size();
		end
	end

endmodule

// ===== tb/tb_midpoint_ellipse_point_generator_unit.sv =====
// Testbench top: clock, reset, register writes, transaction stimulus and verdict.
`timescale 1ns / 1ps
module tb_midpoint_ellipse_point_generator_unit;
	import mepg_pkg::*;
	import mepg_tb_pkg::*;

	localparam int RADIUS_BITS    = 10;
	localparam int COORD_BITS     = 12;
	localparam int SETTLE_CYCLES  = 24;
	localparam int PHASE_ITEMS    = 280;
	localparam int WATCHDOG_LIMIT = 4000;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int fail_count;
	int pending;
	int burst_left = 0;
	int items_sent = 0;
	int idle_cycles = 0;

	mepg_item_if #(.RADIUS_BITS(RADIUS_BITS), .COORD_BITS(COORD_BITS)) item_ch ();
	mepg_result_if #(.COORD_BITS(COORD_BITS)) result_ch ();

	midpoint_ellipse_point_generator_unit #(
		.RADIUS_BITS(RADIUS_BITS),
		.COORD_BITS (COORD_BITS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.item   (item_ch),
		.result (result_ch)
	);

	mepg_checker #(
		.RADIUS_BITS(RADIUS_BITS),
		.COORD_BITS (COORD_BITS)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.pready    (pready),
		.item      (item_ch),
		.result    (result_ch),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		int hold;
		int pick;
		result_ch.ready = 1'b0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold == 0) begin
				pick = $urandom_range(0, 9);
				result_ch.ready <= (pick < 6);
				hold = (pick < 6) ? $urandom_range(1, 60) : $urandom_range(1, 25);
			end else begin
				hold--;
			end
		end
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_item(input logic cmd,
		input logic [RADIUS_BITS-1:0] rx, input logic [RADIUS_BITS-1:0] ry,
		input logic signed [COORD_BITS-1:0] cx, input logic signed [COORD_BITS-1:0] cy);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		item_ch.valid    <= 1'b1;
		item_ch.command  <= cmd;
		item_ch.radius_x <= rx;
		item_ch.radius_y <= ry;
		item_ch.centre_x <= cx;
		item_ch.centre_y <= cy;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	task automatic trace_figure(input int rx, input int ry, input int cx, input int cy,
		input int steps);
		send_item(CMD_START, RADIUS_BITS'(rx), RADIUS_BITS'(ry), COORD_BITS'(cx),
			COORD_BITS'(cy));
		repeat (steps)
			send_item(CMD_STEP, RADIUS_BITS'($urandom()), RADIUS_BITS'($urandom()),
				COORD_BITS'($urandom()), COORD_BITS'($urandom()));
	endtask

	task automatic write_reg(input int unsigned idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'(4 * idx);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// block may still be busy after a start transaction, which yields no result
	task automatic settle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned upper_set [6];
		int unsigned skip_set [6];
		int phase_start;
		int pick;
		int rx, ry, steps;
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		item_ch.valid    = 1'b0;
		item_ch.command  = CMD_START;
		item_ch.radius_x = '0;
		item_ch.radius_y = '0;
		item_ch.centre_x = '0;
		item_ch.centre_y = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(CFG_UPPER_HALF, 32'd0);
		write_reg(CFG_SKIP, 32'd2);

		// step before any start, point at centre, widest figure cut short by restart
		send_item(CMD_STEP, '1, '1, '1, '1);
		trace_figure(0, 0, 0, 0, 3);
		trace_figure(1023, 1023, 2047, -2048, 3);
		trace_figure(3, 2, -2048, 2047, 9);
		trace_figure(2, 0, 5, -5, 3);
		trace_figure(0, 2, -7, 7, 4);

		upper_set = '{0, 1, 0, 1, 0, $urandom_range(0, 1)};
		skip_set  = '{0, 0, 21, 255, 255, $urandom_range(0, 8)};
		for (int ph = 0; ph < 6; ph++) begin
			settle();
			write_reg(CFG_UPPER_HALF, upper_set[ph]);
			write_reg(CFG_SKIP, skip_set[ph]);
			phase_start = items_sent;
			if (skip_set[ph] == 255)
				trace_figure(300, 8, $urandom_range(0, 4095) - 2048,
					$urandom_range(0, 4095) - 2048, 311);
			while (items_sent - phase_start < PHASE_ITEMS) begin
				pick = $urandom_range(0, 19);
				if (pick == 0) begin
					send_item(($urandom_range(0, 1) == 0) ? CMD_START : CMD_STEP,
						RADIUS_BITS'($urandom()), RADIUS_BITS'($urandom()),
						COORD_BITS'($urandom()), COORD_BITS'($urandom()));
				end else if (pick <= 2) begin
					trace_figure($urandom_range(0, 1023), $urandom_range(0, 1023),
						$urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
						$urandom_range(1, 40));
				end else begin
					if (pick <= 6) begin
						rx = $urandom_range(13, 60);
						ry = $urandom_range(13, 60);
					end else begin
						rx = $urandom_range(0, 12);
						ry = $urandom_range(0, 12);
					end
					steps = rx + ry + $urandom_range(1, 3);
					if ($urandom_range(0, 4) == 0)
						steps = $urandom_range(0, rx + ry);
					trace_figure(rx, ry, $urandom_range(0, 4095) - 2048,
						$urandom_range(0, 4095) - 2048, steps);
				end
			end
		end

		settle();
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
